@@ rtl/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted array priority queue package
// Request and response types, cell control and operation codes.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_PEEK   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [ValueWidth-1:0] new_value;
  } sapq_req_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] max_value;
    logic                         was_empty;
    logic                         was_full;
    logic [CountWidth-1:0]        entry_count;
  } sapq_rsp_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } sapq_cell_ctl_t;

endpackage

@@ rtl/sorted_array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted array priority queue
// Max-first queue kept as a descending row of cells; equal values leave
// in arrival order.
//
//   channel   signals                 direction  handshake
//   request   start, busy, req_i      in         start && !busy
//   response  done_o, rsp_o           out        done_o, one cycle
//
// One request per cycle; busy stays low. Every cell compares its entry with
// the broadcast value and shifts in the same cycle, so the response follows
// in the next cycle. Reset clears only the entry count and the done flag;
// entries are written before they are read. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue
  import sapq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  sapq_req_t req_i,
  output logic      done_o,
  output sapq_rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                count_q, count_d;
  logic                         done_q;
  sapq_rsp_t                    rsp_q, rsp_d;
  sapq_cell_ctl_t               ctl;
  logic                         accept, empty, full;
  logic [CW+CountWidth-1:0]     count_wide;

  logic signed [ValueWidth-1:0] value [CAPACITY];
  logic                         ge    [CAPACITY];
  logic                         occ   [CAPACITY];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(CAPACITY));

  always_comb begin
    ctl     = '0;
    count_d = count_q;
    rsp_d   = '0;
    unique case (req_i.mode)
      MODE_INSERT: begin
        if (full) begin
          rsp_d.was_full = 1'b1;
        end else begin
          ctl.ins = accept;
          count_d = count_q + CW'(1);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          rsp_d.was_empty = 1'b1;
        end else begin
          ctl.rem         = accept;
          rsp_d.max_value = value[0];
          count_d         = count_q - CW'(1);
        end
      end
      MODE_PEEK: begin
        if (empty) begin
          rsp_d.was_empty = 1'b1;
        end else begin
          rsp_d.max_value = value[0];
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    count_wide        = {{CountWidth{1'b0}}, count_d};
    rsp_d.entry_count = count_wide[CountWidth-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                         left_ge;
    logic signed [ValueWidth-1:0] left_value, right_value;

    assign occ[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_ge    = 1'b1;
      assign left_value = req_i.new_value;
    end else begin : g_body
      assign left_ge    = ge[i-1];
      assign left_value = value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = value[i];
    end else begin : g_inner
      assign right_value = value[i+1];
    end

    sapq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .new_value_i   (req_i.new_value),
      .occupied_i    (occ[i]),
      .left_ge_i     (left_ge),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .value_o       (value[i]),
      .ge_o          (ge[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request without response");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.mode == MODE_INSERT && full |=> rsp_o.was_full && $stable(count_q))
    else $error("dropped insert changed the queue");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.was_empty |-> count_q == '0 && rsp_o.max_value == '0)
    else $error("empty flag with stored entries");

  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CW'(2) |-> value[0] >= value[1])
    else $error("head entries out of order");

endmodule

@@ rtl/sapq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted array priority queue cell
// Holds one entry; keeps it, takes the new value or shifts from a neighbor.
// ----------------------------------------------------------------------------
module sapq_cell
  import sapq_pkg::*;
(
  input  logic                         clk_i,
  input  sapq_cell_ctl_t               ctl_i,
  input  logic signed [ValueWidth-1:0] new_value_i,
  input  logic                         occupied_i,
  input  logic                         left_ge_i,
  input  logic signed [ValueWidth-1:0] left_value_i,
  input  logic signed [ValueWidth-1:0] right_value_i,
  output logic signed [ValueWidth-1:0] value_o,
  output logic                         ge_o
);

  logic signed [ValueWidth-1:0] value_q, value_d;

  assign ge_o    = occupied_i && (value_q >= new_value_i);
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    if (ctl_i.ins) begin
      if (!ge_o) begin
        value_d = left_ge_i ? new_value_i : left_value_i;
      end
    end else if (ctl_i.rem) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

@@ sim/sorted_array_priority_queue_test.sv @@
// ----------------------------------------------------------------------------
// Sorted array priority queue testbench
// Sends insert, remove, peek and clear requests, starting with a directed
// pass over the corner cases and then running phases that fill the queue,
// drain it and mix all operations. A shadow copy of the queue predicts each
// response, and every response is compared field by field against the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_array_priority_queue_test
  import sapq_pkg::*;
;

  localparam int unsigned Capacity     = 64;
  localparam int unsigned RandomCount  = 1550;
  localparam int unsigned StallLimit   = 500;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  sapq_req_t req_i;
  logic      done_o;
  sapq_rsp_t rsp_o;

  class sapq_shadow;
    logic signed [ValueWidth-1:0] entries[$];
    sapq_rsp_t                    pending_rsp[$];
    int unsigned                  mismatches;

    function void take_request(sapq_req_t req);
      sapq_rsp_t rsp;
      int        pos;
      rsp = '0;
      case (req.mode)
        MODE_INSERT: begin
          if (entries.size() >= Capacity) begin
            rsp.was_full = 1'b1;
          end else begin
            pos = 0;
            while (pos < entries.size() &&
                   $signed(entries[pos]) >= $signed(req.new_value)) begin
              pos++;
            end
            entries.insert(pos, req.new_value);
          end
        end
        MODE_REMOVE: begin
          if (entries.size() == 0) begin
            rsp.was_empty = 1'b1;
          end else begin
            rsp.max_value = entries.pop_front();
          end
        end
        MODE_PEEK: begin
          if (entries.size() == 0) begin
            rsp.was_empty = 1'b1;
          end else begin
            rsp.max_value = entries[0];
          end
        end
        default: begin
          entries.delete();
        end
      endcase
      rsp.entry_count = CountWidth'(entries.size());
      pending_rsp.push_back(rsp);
    endfunction

    function void match_response(sapq_rsp_t rsp);
      sapq_rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_rsp.pop_front();
      if (rsp.max_value !== want.max_value) begin
        $error("max_value: expected %0d, got %0d", want.max_value, rsp.max_value);
        mismatches++;
      end
      if (rsp.was_empty !== want.was_empty) begin
        $error("was_empty: expected %0b, got %0b", want.was_empty, rsp.was_empty);
        mismatches++;
      end
      if (rsp.was_full !== want.was_full) begin
        $error("was_full: expected %0b, got %0b", want.was_full, rsp.was_full);
        mismatches++;
      end
      if (rsp.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count,
               rsp.entry_count);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_rsp.size();
    endfunction
  endclass

  sapq_shadow  shadow;
  int unsigned stall_cycles;

  sorted_array_priority_queue #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    shadow = new();
    stall_cycles = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        shadow.match_response(rsp_o);
      end
      if (start && !busy) begin
        shadow.take_request(req_i);
      end
      if (done_o || (start && !busy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [1:0] mode, input logic [ValueWidth-1:0] value);
    sapq_req_t req;
    req.mode      = mode;
    req.new_value = value;
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_queue();
    start <= 1'b0;
    @(posedge clk_i);
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 3) - 2;
      3, 4:    return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_mode(input int unsigned ins_pct,
                                           input int unsigned rem_pct,
                                           input int unsigned peek_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) return MODE_INSERT;
    if (roll < ins_pct + rem_pct) return MODE_REMOVE;
    if (roll < ins_pct + rem_pct + peek_pct) return MODE_PEEK;
    return MODE_CLEAR;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned phase_kind;
    logic [1:0]  mode;

    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(MODE_PEEK,   32'h1234_5678);
    send_request(MODE_REMOVE, 32'hffff_ffff);
    send_request(MODE_INSERT, 32'h0000_0000);
    send_request(MODE_INSERT, 32'h7fff_ffff);
    send_request(MODE_INSERT, 32'h8000_0000);
    send_request(MODE_INSERT, 32'hffff_ffff);
    send_request(MODE_INSERT, 32'h0000_0001);
    send_request(MODE_INSERT, 32'h7fff_ffff);
    send_request(MODE_PEEK,   32'h0000_0000);
    send_request(MODE_REMOVE, 32'h0000_0000);
    send_request(MODE_REMOVE, 32'h0000_0000);
    send_request(MODE_REMOVE, 32'h0000_0000);
    send_request(MODE_INSERT, 32'h0000_0005);
    send_request(MODE_INSERT, 32'h0000_0005);
    send_request(MODE_CLEAR,  32'h5555_5555);
    send_request(MODE_PEEK,   32'haaaa_aaaa);
    send_request(MODE_REMOVE, 32'h0000_0000);
    send_request(MODE_CLEAR,  32'h0000_0000);
    send_request(MODE_INSERT, 32'h5555_5555);
    send_request(MODE_INSERT, 32'haaaa_aaaa);
    send_request(MODE_REMOVE, 32'h0000_0000);
    send_request(MODE_REMOVE, 32'h0000_0000);
    send_request(MODE_REMOVE, 32'h0000_0000);
    drain_queue();

    sent = 0;
    phase_kind = 0;
    while (sent < RandomCount) begin
      phase_len = (phase_kind == 0) ? $urandom_range(100, 160) : $urandom_range(40, 140);
      repeat (phase_len) begin
        if (sent >= RandomCount) break;
        case (phase_kind)
          0:       mode = pick_mode(80, 9, 9);
          1:       mode = pick_mode(15, 70, 14);
          default: mode = pick_mode(45, 30, 20);
        endcase
        send_request(mode, (mode == MODE_INSERT) ? pick_value() : $urandom);
        sent++;
        if ((sent < 700 || sent >= 1000) && $urandom_range(0, 99) < 4) begin
          hold_off($urandom_range(1, 4));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        drain_queue();
      end
      phase_kind = (phase_kind + 1) % 3;
    end

    drain_queue();
    repeat (4) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
